// ===== sv/sorted_node_key_table_top_assert.svh =====
// Assertion macros for the sorted node key table.
// Used by sorted_node_key_table_top; expects i_clk and i_rst_n in scope.
`ifndef SORTED_NODE_KEY_TABLE_TOP_ASSERT_SVH
`define SORTED_NODE_KEY_TABLE_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SNKT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define SNKT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/sntk_pkg.sv =====
// Shared constants for the sorted node key table: command and status codes,
// fixed field widths. No dependencies.
package sntk_pkg;

    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;
    localparam int FKEY_W  = 32;
    localparam int FIDX_W  = 4;
    localparam int ORDER_W = 5;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FIND   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STAT_W-1:0] ST_BAD_POS   = 2'd3;

    localparam logic [ORDER_W-1:0] ORDER_RESET = 5'd16;

endpackage

// ===== sv/sorted_node_key_table_top.sv =====
// Sorted key array of one tree node, held in a synchronous RAM with one read and one write port.
// Depends on sntk_pkg and sorted_node_key_table_top_assert.svh.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries command, key and slot.
//   Output channel (o_out_valid / i_out_ready) carries one result per command.
//   i_cfg_we with i_cfg_wdata sets the tree order; write only while idle.
// Command steps:
//   Insert walks down from the top key, moving each greater key up one slot,
//   then writes the new key into the freed slot. Delete and find walk up
//   from slot 0, delete then closes the gap in the same pass. Read fetches
//   one slot. Full node, empty node and bad slot skip the walk.
//   The walk is paced by the key RAM: one read and one write per cycle with a
//   registered read port, one key per cycle.
// Only one command is in work at a time; o_in_ready is high while idle.
// The result sits in an output register, so the next command is taken while
// a result still waits. If the receiver stalls, a finished result waits in
// the block until the output register frees.
// Reset clears the key count and the output valid and sets the order to 16;
// RAM contents are not cleared (slots at or past the count are never read).
module sorted_node_key_table_top #(
    parameter int MAX_ORDER = 16,
    parameter int KEY_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sntk_pkg::ORDER_W-1:0]      i_cfg_wdata,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [sntk_pkg::CMD_W-1:0]        i_command,
    input  logic [sntk_pkg::FKEY_W-1:0]       i_key_in,
    input  logic [sntk_pkg::FIDX_W-1:0]       i_slot_index,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [sntk_pkg::STAT_W-1:0]       o_status,
    output logic [sntk_pkg::FIDX_W-1:0]       o_found_index,
    output logic [sntk_pkg::FKEY_W-1:0]       o_key_out,
    output logic [sntk_pkg::FIDX_W-1:0]       o_key_count,
    output logic                              o_has_room
);

    localparam int DEPTH = MAX_ORDER - 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_ORDER);
    localparam int OW    = ($clog2(MAX_ORDER + 1) > sntk_pkg::ORDER_W) ?
                           $clog2(MAX_ORDER + 1) : sntk_pkg::ORDER_W;
    localparam int SW    = (CW > sntk_pkg::FIDX_W) ? CW : sntk_pkg::FIDX_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_PUT  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [KEY_WIDTH-1:0] mem [DEPTH];

    logic [1:0]                    r_state, n_state;
    logic [sntk_pkg::ORDER_W-1:0]  r_node_order;
    logic [CW-1:0]                 r_count, n_count;
    logic [sntk_pkg::CMD_W-1:0]    r_cmd, n_cmd;
    logic [KEY_WIDTH-1:0]          r_key, n_key;
    logic [AW-1:0]                 r_cur, n_cur;
    logic                          r_hit, n_hit;
    logic [KEY_WIDTH-1:0]          r_rd_data;
    logic [sntk_pkg::STAT_W-1:0]   r_res_status, n_res_status;
    logic [AW-1:0]                 r_res_index, n_res_index;
    logic [KEY_WIDTH-1:0]          r_res_key, n_res_key;
    logic                          r_out_valid, n_out_valid;
    logic [sntk_pkg::STAT_W-1:0]   r_out_status, n_out_status;
    logic [sntk_pkg::FIDX_W-1:0]   r_out_index, n_out_index;
    logic [sntk_pkg::FKEY_W-1:0]   r_out_key, n_out_key;
    logic [sntk_pkg::FIDX_W-1:0]   r_out_count, n_out_count;
    logic                          r_out_room, n_out_room;

    logic                 w_accept;
    logic [OW-1:0]        w_ord;
    logic [CW-1:0]        w_cap;
    logic [AW-1:0]        w_top;
    logic                 w_last;
    logic                 w_rd_en;
    logic [AW-1:0]        w_rd_addr;
    logic                 w_wr_en;
    logic [AW-1:0]        w_wr_addr;
    logic [KEY_WIDTH-1:0] w_wr_data;

    assign o_in_ready    = (r_state == S_IDLE);
    assign w_accept      = i_in_valid && o_in_ready;
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_found_index = r_out_index;
    assign o_key_out     = r_out_key;
    assign o_key_count   = r_out_count;
    assign o_has_room    = r_out_room;

    // clamp order to [2, MAX_ORDER], capacity is order - 1
    always_comb begin
        w_ord = OW'(r_node_order);
        if (w_ord < OW'(2)) begin
            w_ord = OW'(2);
        end else if (w_ord > OW'(MAX_ORDER)) begin
            w_ord = OW'(MAX_ORDER);
        end
        w_cap = CW'(w_ord - OW'(1));
    end

    assign w_top  = AW'(r_count - CW'(1));
    assign w_last = (r_cur == w_top);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_cmd        = r_cmd;
        n_key        = r_key;
        n_cur        = r_cur;
        n_hit        = r_hit;
        n_res_status = r_res_status;
        n_res_index  = r_res_index;
        n_res_key    = r_res_key;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_index  = r_out_index;
        n_out_key    = r_out_key;
        n_out_count  = r_out_count;
        n_out_room   = r_out_room;
        w_rd_en      = 1'b0;
        w_rd_addr    = '0;
        w_wr_en      = 1'b0;
        w_wr_addr    = '0;
        w_wr_data    = r_key;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd        = i_command;
                    n_key        = KEY_WIDTH'(i_key_in);
                    n_res_status = sntk_pkg::ST_OK;
                    n_res_index  = '0;
                    n_res_key    = '0;
                    n_hit        = 1'b0;
                    case (i_command)
                        sntk_pkg::CMD_INSERT: begin
                            if (r_count >= w_cap) begin
                                n_res_status = sntk_pkg::ST_FULL;
                                n_state      = S_DONE;
                            end else if (r_count == '0) begin
                                w_wr_en   = 1'b1;
                                w_wr_addr = '0;
                                w_wr_data = KEY_WIDTH'(i_key_in);
                                n_count   = CW'(1);
                                n_state   = S_DONE;
                            end else begin
                                w_rd_en   = 1'b1;
                                w_rd_addr = w_top;
                                n_cur     = w_top;
                                n_state   = S_SCAN;
                            end
                        end
                        sntk_pkg::CMD_DELETE, sntk_pkg::CMD_FIND: begin
                            if (r_count == '0) begin
                                n_res_status = sntk_pkg::ST_NOT_FOUND;
                                n_state      = S_DONE;
                            end else begin
                                w_rd_en   = 1'b1;
                                w_rd_addr = '0;
                                n_cur     = '0;
                                n_state   = S_SCAN;
                            end
                        end
                        default: begin
                            if (SW'(i_slot_index) < SW'(r_count)) begin
                                w_rd_en   = 1'b1;
                                w_rd_addr = AW'(i_slot_index);
                                n_cur     = AW'(i_slot_index);
                                n_state   = S_SCAN;
                            end else begin
                                n_res_status = sntk_pkg::ST_BAD_POS;
                                n_state      = S_DONE;
                            end
                        end
                    endcase
                end
            end
            S_SCAN: begin
                case (r_cmd)
                    sntk_pkg::CMD_INSERT: begin
                        // walking down: greater keys move up one slot
                        w_wr_en   = 1'b1;
                        w_wr_addr = AW'(r_cur + AW'(1));
                        if (r_rd_data > r_key) begin
                            w_wr_data = r_rd_data;
                            if (r_cur == '0) begin
                                n_state = S_PUT;
                            end else begin
                                w_rd_en   = 1'b1;
                                w_rd_addr = AW'(r_cur - AW'(1));
                                n_cur     = AW'(r_cur - AW'(1));
                            end
                        end else begin
                            w_wr_data   = r_key;
                            n_res_index = AW'(r_cur + AW'(1));
                            n_count     = CW'(r_count + CW'(1));
                            n_state     = S_DONE;
                        end
                    end
                    sntk_pkg::CMD_DELETE, sntk_pkg::CMD_FIND: begin
                        if (r_hit) begin
                            // closing the gap behind the deleted key
                            w_wr_en   = 1'b1;
                            w_wr_addr = AW'(r_cur - AW'(1));
                            w_wr_data = r_rd_data;
                        end
                        if (!r_hit && r_rd_data == r_key) begin
                            n_res_index = r_cur;
                            n_hit       = 1'b1;
                        end
                        if (r_hit || r_rd_data == r_key) begin
                            if (w_last || r_cmd == sntk_pkg::CMD_FIND) begin
                                if (r_cmd == sntk_pkg::CMD_DELETE) begin
                                    n_count = CW'(r_count - CW'(1));
                                end
                                n_state = S_DONE;
                            end else begin
                                w_rd_en   = 1'b1;
                                w_rd_addr = AW'(r_cur + AW'(1));
                                n_cur     = AW'(r_cur + AW'(1));
                            end
                        end else if (w_last) begin
                            n_res_status = sntk_pkg::ST_NOT_FOUND;
                            n_state      = S_DONE;
                        end else begin
                            w_rd_en   = 1'b1;
                            w_rd_addr = AW'(r_cur + AW'(1));
                            n_cur     = AW'(r_cur + AW'(1));
                        end
                    end
                    default: begin
                        n_res_key   = r_rd_data;
                        n_res_index = r_cur;
                        n_state     = S_DONE;
                    end
                endcase
            end
            S_PUT: begin
                // every held key was greater: new key lands in slot 0
                w_wr_en     = 1'b1;
                w_wr_addr   = '0;
                w_wr_data   = r_key;
                n_res_index = '0;
                n_count     = CW'(r_count + CW'(1));
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_index  = sntk_pkg::FIDX_W'(r_res_index);
                    n_out_key    = sntk_pkg::FKEY_W'(r_res_key);
                    n_out_count  = sntk_pkg::FIDX_W'(r_count);
                    n_out_room   = (r_count < w_cap);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
            r_node_order <= sntk_pkg::ORDER_RESET;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_node_order <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_key        <= n_key;
        r_cur        <= n_cur;
        r_hit        <= n_hit;
        r_res_status <= n_res_status;
        r_res_index  <= n_res_index;
        r_res_key    <= n_res_key;
        r_out_status <= n_out_status;
        r_out_index  <= n_out_index;
        r_out_key    <= n_out_key;
        r_out_count  <= n_out_count;
        r_out_room   <= n_out_room;
    end

`include "sorted_node_key_table_top_assert.svh"

    `SNKT_ASSERT_NEXT(a_accept_busy, w_accept, r_state != S_IDLE,
        "accepted command left the block idle")
    `SNKT_ASSERT_NOW(a_count_depth, 1'b1, r_count <= CW'(DEPTH),
        "key count beyond table depth")
    `SNKT_ASSERT_NOW(a_scan_in_range, r_state == S_SCAN, r_cur <= w_top,
        "scan pointer past the last held key")
    `SNKT_ASSERT_NOW(a_no_write_done, r_state == S_DONE, !w_wr_en,
        "key RAM written while a result waits")

endmodule

// ===== dv/tb.sv =====
// Testbench for sorted_node_key_table_top: insert, delete, find and read transfers
// with bursty input, stalled output and order changes, checked against a predictor.
// Depends on sntk_pkg and the block's RTL.
module tb;

    localparam int MAX_ORDER    = 16;
    localparam int DEPTH        = MAX_ORDER - 1;
    localparam int LIMIT_CYCLES = 400000;
    localparam int PHASES       = 12;
    localparam int PHASE_OPS    = 120;

    typedef struct packed {
        logic [sntk_pkg::STAT_W-1:0] status;
        logic [sntk_pkg::FIDX_W-1:0] index;
        logic [sntk_pkg::FKEY_W-1:0] key;
        logic [sntk_pkg::FIDX_W-1:0] count;
        logic                        room;
    } t_node_result;

    typedef struct packed {
        logic                         is_cfg;
        logic [sntk_pkg::ORDER_W-1:0] order;
        logic [sntk_pkg::CMD_W-1:0]   cmd;
        logic [sntk_pkg::FKEY_W-1:0]  key;
        logic [sntk_pkg::FIDX_W-1:0]  slot;
        logic                         typed;
        t_node_result                 res;
    } t_stim_row;

    logic                         i_clk        = 1'b0;
    logic                         i_rst_n      = 1'b0;
    logic                         i_cfg_we     = 1'b0;
    logic [sntk_pkg::ORDER_W-1:0] i_cfg_wdata  = sntk_pkg::ORDER_RESET;
    logic                         i_in_valid   = 1'b0;
    logic [sntk_pkg::CMD_W-1:0]   i_command    = sntk_pkg::CMD_INSERT;
    logic [sntk_pkg::FKEY_W-1:0]  i_key_in     = '0;
    logic [sntk_pkg::FIDX_W-1:0]  i_slot_index = '0;
    logic                         i_out_ready  = 1'b0;
    logic                         o_in_ready;
    logic                         o_out_valid;
    logic [sntk_pkg::STAT_W-1:0]  o_status;
    logic [sntk_pkg::FIDX_W-1:0]  o_found_index;
    logic [sntk_pkg::FKEY_W-1:0]  o_key_out;
    logic [sntk_pkg::FIDX_W-1:0]  o_key_count;
    logic                         o_has_room;

    // predicted node contents
    logic [sntk_pkg::FKEY_W-1:0]  key_slots [DEPTH];
    int                           key_total  = 0;
    logic [sntk_pkg::ORDER_W-1:0] tree_order = sntk_pkg::ORDER_RESET;

    t_node_result                 pending_results [$];
    t_node_result                 want_res;
    t_node_result                 got_res;
    logic [sntk_pkg::ORDER_W-1:0] phase_orders [PHASES] =
        '{5'd16, 5'd2, 5'd9, 5'd31, 5'd0, 5'd3, 5'd16, 5'd1, 5'd17, 5'd5, 5'd15, 5'd8};

    int errors      = 0;
    int items_sent  = 0;
    int cfg_writes  = 0;
    int cycle_count = 0;
    int burst_left  = 0;
    int rx_tick     = 0;
    int stall_mode  = 0;
    int status_seen [4] = '{0, 0, 0, 0};

    sorted_node_key_table_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_key_in      (i_key_in),
        .i_slot_index  (i_slot_index),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_found_index (o_found_index),
        .o_key_out     (o_key_out),
        .o_key_count   (o_key_count),
        .o_has_room    (o_has_room)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int node_capacity();
        int ord;
        ord = tree_order;
        if (ord < 2) ord = 2;
        if (ord > MAX_ORDER) ord = MAX_ORDER;
        return ord - 1;
    endfunction

    function automatic t_node_result apply_key_op(input logic [sntk_pkg::CMD_W-1:0] cmd,
                                                  input logic [sntk_pkg::FKEY_W-1:0] key,
                                                  input logic [sntk_pkg::FIDX_W-1:0] slot);
        t_node_result r;
        int           cap;
        int           pos;
        int           i;
        bit           hit;
        r = '0;
        r.status = sntk_pkg::ST_OK;
        cap = node_capacity();
        case (cmd)
            sntk_pkg::CMD_INSERT: begin
                if (key_total >= cap) begin
                    r.status = sntk_pkg::ST_FULL;
                end else begin
                    // goes ahead of the first strictly greater key
                    pos = key_total;
                    for (i = 0; i < key_total; i++)
                        if (pos == key_total && key_slots[i] > key) pos = i;
                    for (i = key_total; i > pos; i--)
                        key_slots[i] = key_slots[i-1];
                    key_slots[pos] = key;
                    key_total++;
                    r.index = sntk_pkg::FIDX_W'(pos);
                end
            end
            sntk_pkg::CMD_DELETE, sntk_pkg::CMD_FIND: begin
                hit = 1'b0;
                pos = 0;
                for (i = 0; i < key_total; i++)
                    if (!hit && key_slots[i] == key) begin
                        hit = 1'b1;
                        pos = i;
                    end
                if (!hit) begin
                    r.status = sntk_pkg::ST_NOT_FOUND;
                end else begin
                    r.index = sntk_pkg::FIDX_W'(pos);
                    if (cmd == sntk_pkg::CMD_DELETE) begin
                        for (i = pos; i + 1 < key_total; i++)
                            key_slots[i] = key_slots[i+1];
                        key_total--;
                    end
                end
            end
            default: begin
                if (slot < key_total) begin
                    r.index = slot;
                    r.key   = key_slots[slot];
                end else begin
                    r.status = sntk_pkg::ST_BAD_POS;
                end
            end
        endcase
        r.count = sntk_pkg::FIDX_W'(key_total);
        r.room  = (key_total < cap);
        status_seen[r.status]++;
        return r;
    endfunction

    function automatic t_stim_row chk_row(input logic [sntk_pkg::CMD_W-1:0] cmd,
                                          input logic [sntk_pkg::FKEY_W-1:0] key,
                                          input int slot,
                                          input logic [sntk_pkg::STAT_W-1:0] st,
                                          input int idx,
                                          input logic [sntk_pkg::FKEY_W-1:0] kout,
                                          input int cnt,
                                          input int room);
        t_stim_row row;
        row = '0;
        row.cmd = cmd;
        row.key = key;
        row.slot = sntk_pkg::FIDX_W'(slot);
        row.typed = 1'b1;
        row.res = {st, idx[sntk_pkg::FIDX_W-1:0], kout, cnt[sntk_pkg::FIDX_W-1:0], room[0]};
        return row;
    endfunction

    function automatic t_stim_row op_row(input logic [sntk_pkg::CMD_W-1:0] cmd,
                                         input logic [sntk_pkg::FKEY_W-1:0] key,
                                         input int slot);
        t_stim_row row;
        row = '0;
        row.cmd = cmd;
        row.key = key;
        row.slot = sntk_pkg::FIDX_W'(slot);
        return row;
    endfunction

    function automatic t_stim_row cfg_row(input logic [sntk_pkg::ORDER_W-1:0] order);
        t_stim_row row;
        row = '0;
        row.is_cfg = 1'b1;
        row.order = order;
        return row;
    endfunction

    // fill phases lean on inserts, drain phases on deletes; keys are often held ones or their neighbours
    function automatic t_stim_row random_row(input bit fill);
        t_stim_row row;
        int        r;
        int        ins;
        row = '0;
        r = $urandom_range(0, 99);
        ins = fill ? 60 : 30;
        if (r < ins) row.cmd = sntk_pkg::CMD_INSERT;
        else if (r < ins + (fill ? 20 : 40)) row.cmd = sntk_pkg::CMD_DELETE;
        else if (r[0]) row.cmd = sntk_pkg::CMD_FIND;
        else row.cmd = sntk_pkg::CMD_READ;
        case ($urandom_range(0, 3))
            0: row.key = $urandom_range(0, 15);
            1: row.key = key_total ? key_slots[$urandom_range(0, key_total - 1)] : $urandom;
            2: row.key = $urandom;
            default: row.key = key_total ? key_slots[$urandom_range(0, key_total - 1)] + 1
                                         : 32'hFFFF_FFFF;
        endcase
        row.slot = sntk_pkg::FIDX_W'($urandom_range(0, 1) ? $urandom_range(0, 15)
                                                          : $urandom_range(0, key_total));
        return row;
    endfunction

    task automatic send_op(input t_stim_row row);
        t_node_result pred;
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_command    <= row.cmd;
        i_key_in     <= row.key;
        i_slot_index <= row.slot;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pred = apply_key_op(row.cmd, row.key, row.slot);
        pending_results.push_back(row.typed ? row.res : pred);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                      : $urandom_range(0, 12);
        end
    endtask

    // order changes only with the block drained
    task automatic write_order(input logic [sntk_pkg::ORDER_W-1:0] value);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        tree_order = value;
        cfg_writes++;
    endtask

    // output stall pattern, with the mode picked at random from four
    always @(negedge i_clk) begin
        if (rx_tick % 64 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= (rx_tick % 3 == 0);
            2: i_out_ready <= $urandom_range(0, 1);
            default: i_out_ready <= (rx_tick % 8 >= 5);
        endcase
        rx_tick++;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("%0t: run did not finish within %0d cycles", $time, LIMIT_CYCLES);
            $display("CHECK FAILED");
            $finish;
        end else if (i_rst_n && o_out_valid && i_out_ready) begin
            got_res = {o_status, o_found_index, o_key_out, o_key_count, o_has_room};
            if (pending_results.size() == 0) begin
                $display("%0t: result transfer with none expected: st=%0d idx=%0d key=%h",
                         $time, got_res.status, got_res.index, got_res.key);
                errors++;
            end else begin
                want_res = pending_results.pop_front();
                if (got_res.status !== want_res.status || got_res.index !== want_res.index ||
                    got_res.key !== want_res.key || got_res.count !== want_res.count ||
                    got_res.room !== want_res.room) begin
                    $display("%0t: mismatch expected st=%0d idx=%0d key=%h cnt=%0d room=%0b",
                             $time, want_res.status, want_res.index, want_res.key,
                             want_res.count, want_res.room);
                    $display("%0t:          actual   st=%0d idx=%0d key=%h cnt=%0d room=%0b",
                             $time, got_res.status, got_res.index, got_res.key,
                             got_res.count, got_res.room);
                    errors++;
                end
            end
        end
    end

    initial begin
        t_stim_row rows [$];
        int        p;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty node, then extremes and equal keys at order 16
        rows.push_back(chk_row(sntk_pkg::CMD_READ, 32'h0, 0,
                               sntk_pkg::ST_BAD_POS, 0, 32'h0, 0, 1));
        rows.push_back(chk_row(sntk_pkg::CMD_FIND, 32'h5, 0,
                               sntk_pkg::ST_NOT_FOUND, 0, 32'h0, 0, 1));
        rows.push_back(chk_row(sntk_pkg::CMD_DELETE, 32'h5, 0,
                               sntk_pkg::ST_NOT_FOUND, 0, 32'h0, 0, 1));
        rows.push_back(chk_row(sntk_pkg::CMD_INSERT, 32'hFFFF_FFFF, 0,
                               sntk_pkg::ST_OK, 0, 32'h0, 1, 1));
        rows.push_back(chk_row(sntk_pkg::CMD_INSERT, 32'h0, 0,
                               sntk_pkg::ST_OK, 0, 32'h0, 2, 1));
        rows.push_back(chk_row(sntk_pkg::CMD_INSERT, 32'h0, 0,
                               sntk_pkg::ST_OK, 1, 32'h0, 3, 1));
        rows.push_back(chk_row(sntk_pkg::CMD_INSERT, 32'h8000_0000, 0,
                               sntk_pkg::ST_OK, 2, 32'h0, 4, 1));
        rows.push_back(chk_row(sntk_pkg::CMD_INSERT, 32'h7FFF_FFFF, 0,
                               sntk_pkg::ST_OK, 2, 32'h0, 5, 1));
        rows.push_back(chk_row(sntk_pkg::CMD_READ, 32'h0, 4,
                               sntk_pkg::ST_OK, 4, 32'hFFFF_FFFF, 5, 1));
        rows.push_back(chk_row(sntk_pkg::CMD_READ, 32'h0, 5,
                               sntk_pkg::ST_BAD_POS, 0, 32'h0, 5, 1));
        rows.push_back(chk_row(sntk_pkg::CMD_READ, 32'hFFFF_FFFF, 15,
                               sntk_pkg::ST_BAD_POS, 0, 32'h0, 5, 1));
        rows.push_back(chk_row(sntk_pkg::CMD_FIND, 32'h0, 0,
                               sntk_pkg::ST_OK, 0, 32'h0, 5, 1));
        rows.push_back(chk_row(sntk_pkg::CMD_DELETE, 32'h0, 0,
                               sntk_pkg::ST_OK, 0, 32'h0, 4, 1));
        rows.push_back(chk_row(sntk_pkg::CMD_FIND, 32'h8000_0000, 0,
                               sntk_pkg::ST_OK, 2, 32'h0, 4, 1));
        rows.push_back(chk_row(sntk_pkg::CMD_DELETE, 32'h8000_0000, 0,
                               sntk_pkg::ST_OK, 2, 32'h0, 3, 1));
        rows.push_back(op_row(sntk_pkg::CMD_INSERT, 32'h1234_5678, 0));
        rows.push_back(op_row(sntk_pkg::CMD_READ,   32'h0,         2));
        // order lowered under the count: node reports full until deletes catch up
        rows.push_back(cfg_row(5'd4));
        rows.push_back(chk_row(sntk_pkg::CMD_INSERT, 32'h1, 0,
                               sntk_pkg::ST_FULL, 0, 32'h0, 4, 0));
        rows.push_back(chk_row(sntk_pkg::CMD_DELETE, 32'h1234_5678, 0,
                               sntk_pkg::ST_OK, 1, 32'h0, 3, 0));
        rows.push_back(cfg_row(5'd2));
        rows.push_back(chk_row(sntk_pkg::CMD_INSERT, 32'h5, 0,
                               sntk_pkg::ST_FULL, 0, 32'h0, 3, 0));
        rows.push_back(chk_row(sntk_pkg::CMD_DELETE, 32'h7FFF_FFFF, 0,
                               sntk_pkg::ST_OK, 1, 32'h0, 2, 0));
        rows.push_back(chk_row(sntk_pkg::CMD_DELETE, 32'h0, 0,
                               sntk_pkg::ST_OK, 0, 32'h0, 1, 0));
        rows.push_back(chk_row(sntk_pkg::CMD_DELETE, 32'hFFFF_FFFF, 0,
                               sntk_pkg::ST_OK, 0, 32'h0, 0, 1));
        rows.push_back(chk_row(sntk_pkg::CMD_INSERT, 32'd42, 0,
                               sntk_pkg::ST_OK, 0, 32'h0, 1, 0));
        // out-of-range orders clamp to 2 and to 16
        rows.push_back(cfg_row(5'd0));
        rows.push_back(chk_row(sntk_pkg::CMD_INSERT, 32'd9, 0,
                               sntk_pkg::ST_FULL, 0, 32'h0, 1, 0));
        rows.push_back(cfg_row(5'd31));
        rows.push_back(chk_row(sntk_pkg::CMD_INSERT, 32'd9, 0,
                               sntk_pkg::ST_OK, 0, 32'h0, 2, 1));
        rows.push_back(chk_row(sntk_pkg::CMD_READ, 32'h0, 1,
                               sntk_pkg::ST_OK, 1, 32'd42, 2, 1));

        foreach (rows[r]) begin
            if (rows[r].is_cfg) write_order(rows[r].order);
            else send_op(rows[r]);
        end

        phase_orders[PHASES-1] = sntk_pkg::ORDER_W'($urandom_range(2, MAX_ORDER));
        for (p = 0; p < PHASES; p++) begin
            write_order(phase_orders[p]);
            repeat (PHASE_OPS) send_op(random_row(p % 2 == 0));
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("covered %0d commands over %0d order settings", items_sent, cfg_writes + 1);
        $display("results: %0d ok, %0d full, %0d key missing, %0d bad slot",
                 status_seen[sntk_pkg::ST_OK], status_seen[sntk_pkg::ST_FULL],
                 status_seen[sntk_pkg::ST_NOT_FOUND], status_seen[sntk_pkg::ST_BAD_POS]);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
